@@ rtl/hbrp_pkg.sv @@
// shared types, character codes and constants for the byte-range header parser
// no dependencies; every other rtl file imports this package

package hbrp_pkg;

	// longest header value taken, spaces included
	localparam logic [7:0] MAX_HEADER_BYTES = 8'd126;

	// length of the "bytes=" prefix
	localparam logic [2:0] PREFIX_LEN = 3'd6;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// result kinds
	localparam logic [1:0] KIND_RANGE  = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// parser phase
	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_OPEN,
		PH_FIRST,
		PH_DASH,
		PH_SECOND,
		PH_SKIP
	} phase_t;

	// one parsed byte handed to the range stage
	typedef struct packed {
		logic        close;
		logic        fin;
		logic        fail;
		logic [31:0] first_num;
		logic [31:0] second_num;
		logic        first_seen;
		logic        second_seen;
	} ev_t;

	// one result item
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic        end_of_run;
	} res_t;

	// lower-case prefix text by position
	function automatic logic [7:0] key_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h62;
			3'd1:    ch = 8'h79;
			3'd2:    ch = 8'h74;
			3'd3:    ch = 8'h65;
			3'd4:    ch = 8'h73;
			3'd5:    ch = 8'h3D;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/http_byte_range_parser_core.sv @@
// top level of the HTTP Range header parser: stream ports, config register port
// depends on hbrp_pkg, hbrp_parse, hbrp_norm and hbrp_fifo

// Takes the Range header value one byte per transfer (tlast on the final byte) and
// returns one transfer per clamped range, then a closing accepted or rejected transfer
// with tlast set. A byte is taken every cycle while the four-entry result queue has room
// for two more results; a byte's results pass the input register and event register before
// they enter the queue. The output drains one result per cycle while m_axis_tready is high,
// so a closing final byte yields two results (range plus verdict). Ranges sent before a
// rejected verdict are void. The user must write content_length only while idle (unenforced).

module http_byte_range_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// content length register
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	// header bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
	input  logic        s_axis_tlast,   // final_byte
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] range_start, [63:32] range_end
	output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
	output logic        m_axis_tlast    // end_of_run
);
	import hbrp_pkg::*;

	ev_t        ev;
	logic       ev_valid, ev_ready;
	logic       space_ok;
	logic [1:0] wr_n;
	res_t       wr0, wr1, out_data;

	// byte parser
	hbrp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.ev_valid (ev_valid),
		.ev       (ev),
		.ev_ready (ev_ready)
	);

	// clamp and verdict
	hbrp_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.ev_ready  (ev_ready),
		.space_ok  (space_ok),
		.wr_n      (wr_n),
		.wr0       (wr0),
		.wr1       (wr1)
	);

	// result queue
	hbrp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_n      (wr_n),
		.wr0       (wr0),
		.wr1       (wr1),
		.space_ok  (space_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {out_data.range_end, out_data.range_start};
	assign m_axis_tuser = out_data.result_kind;
	assign m_axis_tlast = out_data.end_of_run;

endmodule

@@ rtl/hbrp_parse.sv @@
// byte parser: input register, prefix match, element grammar and number accumulation
// depends on hbrp_pkg; feeds hbrp_norm through a registered event stage

module hbrp_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          ev_valid,
	output hbrp_pkg::ev_t ev,
	input  logic          ev_ready
);
	import hbrp_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	phase_t      phase_q, phase_c, phase_d;
	logic [2:0]  pos_q, pos_d;
	logic [31:0] first_q, second_q, first_d, second_d;
	logic        fseen_q, sseen_q, fseen_d, sseen_d;
	logic        open_q, open_d;
	logic [7:0]  bytes_q, bytes_d;
	logic        kept_q, kept_d;
	logic        failed_q, failed_d;

	logic        s2_ready, step;
	logic        fail_len, live, is_digit, is_comma, is_dash, prefix_hit;
	logic [7:0]  lower, dig_diff;
	logic [3:0]  dig;
	logic [31:0] acc_base, acc_val;
	logic [35:0] prod;
	logic        acc_ovf;

	logic [31:0] f_e, s_e;
	logic        fs_e, ss_e, open_e, open_c, kept_c;
	logic        fail_c, close_comma, close_fin;
	ev_t         ev_d;

	// handshake between input register and event stage
	assign s2_ready = !ev_valid || ev_ready;
	assign step     = v_s1 && s2_ready;
	assign in_ready = !v_s1 || s2_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// byte decode
	assign fail_len   = !failed_q && (bytes_q >= MAX_HEADER_BYTES);
	assign live       = !failed_q && !fail_len && (byte_s1 != CH_SPACE);
	assign is_digit   = byte_s1 inside {[CH_0:CH_9]};
	assign is_comma   = byte_s1 == CH_COMMA;
	assign is_dash    = byte_s1 == CH_DASH;
	assign dig_diff   = byte_s1 - CH_0;
	assign dig        = is_digit ? dig_diff[3:0] : 4'd0;
	assign lower      = (byte_s1 inside {[CH_UA:CH_UZ]}) ? (byte_s1 | CASE_BIT) : byte_s1;
	assign prefix_hit = (pos_q < PREFIX_LEN) && (lower == key_char(pos_q));

	// decimal accumulate: value * 10 + digit, saturating
	assign acc_base = (phase_q == PH_FIRST)  ? first_q  :
	                  (phase_q == PH_SECOND) ? second_q : 32'd0;
	assign prod     = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) + {32'd0, dig};
	assign acc_ovf  = |prod[35:32];
	assign acc_val  = acc_ovf ? 32'hFFFF_FFFF : prod[31:0];

	// phase next state
	always_comb begin
		phase_c = phase_q;
		if (live) begin
			if (phase_q == PH_PREFIX) begin
				if (prefix_hit && (pos_q == PREFIX_LEN - 3'd1)) begin
					phase_c = PH_OPEN;
				end
			end else if (is_comma) begin
				if (open_q) begin
					phase_c = PH_OPEN;
				end
			end else begin
				case (phase_q)
					PH_OPEN, PH_FIRST: begin
						phase_c = is_digit ? PH_FIRST : (is_dash ? PH_DASH : PH_SKIP);
					end
					PH_DASH, PH_SECOND: begin
						phase_c = is_digit ? PH_SECOND : PH_SKIP;
					end
					default: phase_c = PH_SKIP;
				endcase
			end
		end
		phase_d = last_s1 ? PH_PREFIX : phase_c;
	end

	// element data, failure, events and run counters
	always_comb begin
		fail_c      = failed_q || fail_len;
		pos_d       = pos_q;
		f_e         = first_q;
		s_e         = second_q;
		fs_e        = fseen_q;
		ss_e        = sseen_q;
		open_e      = open_q;
		close_comma = 1'b0;
		if (live) begin
			if (phase_q == PH_PREFIX) begin
				if (prefix_hit) begin
					pos_d = pos_q + 3'd1;
				end else begin
					fail_c = 1'b1;
				end
			end else if (is_comma) begin
				if (open_q) begin
					close_comma = 1'b1;
				end else begin
					fail_c = 1'b1;
				end
			end else begin
				open_e = 1'b1;
				if (is_digit) begin
					case (phase_q)
						PH_OPEN, PH_FIRST: begin
							f_e  = acc_val;
							fs_e = 1'b1;
							if (acc_ovf) begin
								fail_c = 1'b1;
							end
						end
						PH_DASH, PH_SECOND: begin
							s_e  = acc_val;
							ss_e = 1'b1;
							if (acc_ovf) begin
								fail_c = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
		end

		kept_c    = kept_q || close_comma;
		open_c    = open_e && !close_comma;
		close_fin = last_s1 && !fail_c && (phase_c != PH_PREFIX) && open_c;

		ev_d.close       = close_comma || close_fin;
		ev_d.fin         = last_s1;
		ev_d.fail        = fail_c || (last_s1 && ((phase_c == PH_PREFIX) || (!open_c && !kept_c)));
		ev_d.first_num   = f_e;
		ev_d.second_num  = s_e;
		ev_d.first_seen  = fs_e;
		ev_d.second_seen = ss_e;

		bytes_d  = (failed_q || fail_len) ? bytes_q : bytes_q + 8'd1;
		failed_d = fail_c;
		kept_d   = kept_c;
		first_d  = f_e;
		second_d = s_e;
		fseen_d  = fs_e;
		sseen_d  = ss_e;
		open_d   = open_e;
		if (close_comma || last_s1) begin
			first_d  = 32'hFFFF_FFFF;
			second_d = 32'hFFFF_FFFF;
			fseen_d  = 1'b0;
			sseen_d  = 1'b0;
			open_d   = 1'b0;
		end
		if (last_s1) begin
			pos_d    = 3'd0;
			bytes_d  = 8'd0;
			kept_d   = 1'b0;
			failed_d = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PREFIX;
			pos_q    <= 3'd0;
			first_q  <= 32'hFFFF_FFFF;
			second_q <= 32'hFFFF_FFFF;
			fseen_q  <= 1'b0;
			sseen_q  <= 1'b0;
			open_q   <= 1'b0;
			bytes_q  <= 8'd0;
			kept_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			first_q  <= first_d;
			second_q <= second_d;
			fseen_q  <= fseen_d;
			sseen_q  <= sseen_d;
			open_q   <= open_d;
			bytes_q  <= bytes_d;
			kept_q   <= kept_d;
			failed_q <= failed_d;
		end
	end

	// event stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else if (s2_ready) begin
			ev_valid <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev <= ev_d;
		end
	end

	// no element can be open while the prefix is still being matched
	a_prefix_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX) |-> !open_q)
		else $error("element open during prefix match");

	// an unseen first number always holds its cleared value
	a_first_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!fseen_q |-> (first_q == 32'hFFFF_FFFF))
		else $error("first number dirty while unseen");

	// a closing element never comes with a parse failure
	a_close_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && ev.close) |-> !ev.fail)
		else $error("element closed on a failed byte");

endmodule

@@ rtl/hbrp_norm.sv @@
// range stage: clamps closed elements against the content length and decides the verdict
// depends on hbrp_pkg; takes events from hbrp_parse and writes up to two results to hbrp_fifo

module hbrp_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata,
	input  logic           ev_valid,
	input  hbrp_pkg::ev_t  ev,
	output logic           ev_ready,
	input  logic           space_ok,
	output logic [1:0]     wr_n,
	output hbrp_pkg::res_t wr0,
	output hbrp_pkg::res_t wr1
);
	import hbrp_pkg::*;

	logic [31:0] len_q;
	logic        norm_fail_q, norm_fail_d;
	logic        take, ok, len_zero;
	logic [31:0] len_m1, rstart, rend;
	res_t        rng, acc, rej;

	// content length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 32'd0;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	assign ev_ready = space_ok;
	assign take     = ev_valid && space_ok;

	// clamp the element against the length
	assign len_zero = len_q == 32'd0;
	assign len_m1   = len_q - 32'd1;

	always_comb begin
		if (ev.first_seen) begin
			ok     = !len_zero && (ev.first_num < len_q) &&
			         !(ev.second_seen && (ev.second_num < ev.first_num));
			rstart = ev.first_num;
			rend   = (ev.second_seen && (ev.second_num < len_q)) ? ev.second_num : len_m1;
		end else begin
			ok     = ev.second_seen && !len_zero && (ev.second_num != 32'd0);
			rstart = (ev.second_num >= len_q) ? 32'd0 : len_q - ev.second_num;
			rend   = len_m1;
		end
	end

	assign rng = '{result_kind: KIND_RANGE, range_start: rstart, range_end: rend,
	               end_of_run: 1'b0};
	assign acc = '{result_kind: KIND_ACCEPT, range_start: 32'd0, range_end: 32'd0,
	               end_of_run: 1'b1};
	assign rej = '{result_kind: KIND_REJECT, range_start: 32'd0, range_end: 32'd0,
	               end_of_run: 1'b1};

	// results for this byte
	always_comb begin
		wr_n        = 2'd0;
		wr0         = rng;
		wr1         = acc;
		norm_fail_d = norm_fail_q;
		if (take) begin
			if (ev.fin) begin
				norm_fail_d = 1'b0;
				if (ev.fail || norm_fail_q || (ev.close && !ok)) begin
					wr0  = rej;
					wr_n = 2'd1;
				end else if (ev.close) begin
					wr_n = 2'd2;
				end else begin
					wr0  = acc;
					wr_n = 2'd1;
				end
			end else if (ev.close) begin
				if (!ok) begin
					norm_fail_d = 1'b1;
				end else if (!norm_fail_q) begin
					wr_n = 2'd1;
				end
			end
		end
	end

	// a failed clamp voids the rest of the header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_fail_q <= 1'b0;
		end else begin
			norm_fail_q <= norm_fail_d;
		end
	end

endmodule

@@ rtl/hbrp_fifo.sv @@
// result queue: up to two writes and one read per cycle, register storage
// depends on hbrp_pkg; sits between hbrp_norm and the output stream

module hbrp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     wr_n,
	input  hbrp_pkg::res_t wr0,
	input  hbrp_pkg::res_t wr1,
	output logic           space_ok,
	output logic           out_valid,
	input  logic           out_ready,
	output hbrp_pkg::res_t out_data
);
	import hbrp_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               rd;

	assign out_valid = cnt_q != FIFO_CW'(0);
	assign out_data  = mem_q[rp_q];
	assign rd        = out_valid && out_ready;
	assign space_ok  = cnt_q <= FIFO_CW'(FIFO_DEPTH - 2);

	// storage
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) begin
			mem_q[wp_q] <= wr0;
		end
		if (wr_n == 2'd2) begin
			mem_q[wp_q + FIFO_AW'(1)] <= wr1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(wr_n);
			rp_q  <= rp_q + FIFO_AW'(rd);
			cnt_q <= cnt_q + FIFO_CW'(wr_n) - FIFO_CW'(rd);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overfilled");

	// writes only arrive when room for two was announced
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_n != 2'd0) |-> space_ok)
		else $error("result write without room");

endmodule
